// ===== design/prsw_pkg.sv =====
// ----------------------------------------------------------------------------
// prsw_pkg
// Shared types, codes and sizing constants for the partial-reliability
// stop-and-wait engine.
// ----------------------------------------------------------------------------
`default_nettype none

package prsw_pkg;

  // Size of the watched loss window.
  localparam int unsigned WINDOW = 10;

  // Window position and mark counter widths follow from the window size.
  localparam int unsigned POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);

  // Fixed field widths.
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned LCOUNT_W = 4;

  // Reset value of the tolerated loss percentage.
  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(20);

  // Scale of the percentage compare: count * 100 > pct * WINDOW.
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned CMP_W     = $clog2(PCT_SCALE * WINDOW + (1 << PCT_W) * WINDOW);

  // Request codes.
  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_REPLY   = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_DATA    = 2'd3
  } req_type_t;

  // Result action codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_TX      = 3'd0,
    ACT_RETX    = 3'd1,
    ACT_DONE    = 3'd2,
    ACT_DELIVER = 3'd3,
    ACT_DUP     = 3'd4
  } action_t;

  // One request beat as held in the input register.
  typedef struct packed {
    logic [1:0] req_type;
    logic       reply_ack_flag;
    logic       reply_ack_num;
    logic       rx_seq;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                seq_out;
    logic [LCOUNT_W-1:0] loss_count;
    logic                over_threshold;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/prsw_req_if.sv =====
// ----------------------------------------------------------------------------
// prsw_req_if
// Valid/ready channel carrying one request beat into the engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface prsw_req_if;

  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       reply_ack_flag;
  logic       reply_ack_num;
  logic       rx_seq;

  modport source (
    output valid, req_type, reply_ack_flag, reply_ack_num, rx_seq,
    input  ready
  );

  modport sink (
    input  valid, req_type, reply_ack_flag, reply_ack_num, rx_seq,
    output ready
  );

endinterface

`default_nettype wire

// ===== design/prsw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// prsw_rsp_if
// Valid/ready channel carrying one result beat out of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface prsw_rsp_if;

  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       seq_out;
  logic [3:0] loss_count;
  logic       over_threshold;

  modport source (
    output valid, action, seq_out, loss_count, over_threshold,
    input  ready
  );

  modport sink (
    input  valid, action, seq_out, loss_count, over_threshold,
    output ready
  );

endinterface

`default_nettype wire

// ===== design/prsw_core.sv =====
// ----------------------------------------------------------------------------
// prsw_core
// Protocol state (sequence bit, loss window, count, retry flag, tolerance
// register) and the single-pass update that turns one request into a result.
// ----------------------------------------------------------------------------
`default_nettype none

module prsw_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire prsw_pkg::req_t                req,
  input  wire logic                          cfg_we,
  input  wire logic [prsw_pkg::PCT_W-1:0]    cfg_wdata,
  output prsw_pkg::rsp_t                     rsp
);
  import prsw_pkg::*;

  // Architectural state.
  logic                 seq_bit_r,  seq_bit_nxt;
  logic [WINDOW-1:0]    marks_r,    marks_nxt;
  logic [CNT_W-1:0]     marked_r,   marked_nxt;
  logic [POS_W-1:0]     pos_r,      pos_nxt;
  logic                 retry_r,    retry_nxt;
  logic [PCT_W-1:0]     pct_r;

  logic                 good;
  logic                 over;
  logic [CMP_W-1:0]     loss_scaled;
  logic [CMP_W-1:0]     limit_scaled;
  logic [ACTION_W-1:0]  action;
  logic                 seq_o;

  // Tolerance limit scaled by the window size.
  assign limit_scaled = CMP_W'(pct_r) * CMP_W'(WINDOW);

  // Next-state and result for the request in the input register.
  always_comb begin
    seq_bit_nxt = seq_bit_r;
    marks_nxt   = marks_r;
    marked_nxt  = marked_r;
    pos_nxt     = pos_r;
    retry_nxt   = retry_r;
    good        = 1'b0;
    action      = ACT_TX;
    seq_o       = seq_bit_r;

    unique case (req_type_t'(req.req_type))
      REQ_START: begin
        retry_nxt = 1'b0;
        action    = ACT_TX;
        seq_o     = seq_bit_r;
      end
      REQ_DATA: begin
        if (req.rx_seq == seq_bit_r) begin
          seq_bit_nxt = ~seq_bit_r;
          action      = ACT_DELIVER;
        end else begin
          action      = ACT_DUP;
        end
        seq_o = req.rx_seq;
      end
      default: begin
        // Reply or timeout: update the mark at the current window slot.
        good = (req_type_t'(req.req_type) == REQ_REPLY) && req.reply_ack_flag
               && (req.reply_ack_num == seq_bit_r);
        if (good) begin
          seq_bit_nxt = ~seq_bit_r;
          if (marks_r[pos_r]) begin
            marks_nxt[pos_r] = 1'b0;
            if (marked_r != '0) begin
              marked_nxt = marked_r - CNT_W'(1);
            end
          end
        end else if (!marks_r[pos_r] && !retry_r) begin
          marks_nxt[pos_r] = 1'b1;
          marked_nxt       = marked_r + CNT_W'(1);
        end
        seq_o = seq_bit_nxt;
      end
    endcase

    // The loss compare always looks at the count after the update.
    loss_scaled = CMP_W'(marked_nxt) * CMP_W'(PCT_SCALE);
    over        = loss_scaled > limit_scaled;

    // Reply or timeout decides between retransmission and completion.
    if (req_type_t'(req.req_type) == REQ_REPLY ||
        req_type_t'(req.req_type) == REQ_TIMEOUT) begin
      if (over) begin
        retry_nxt = 1'b1;
        action    = ACT_RETX;
      end else begin
        retry_nxt = 1'b0;
        action    = ACT_DONE;
        pos_nxt   = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + POS_W'(1);
      end
    end
  end

  assign rsp.action         = action;
  assign rsp.seq_out        = seq_o;
  assign rsp.loss_count     = LCOUNT_W'(marked_nxt);
  assign rsp.over_threshold = over;

  // State registers advance once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_bit_r <= 1'b0;
      marks_r   <= '0;
      marked_r  <= '0;
      pos_r     <= '0;
      retry_r   <= 1'b0;
    end else if (step) begin
      seq_bit_r <= seq_bit_nxt;
      marks_r   <= marks_nxt;
      marked_r  <= marked_nxt;
      pos_r     <= pos_nxt;
      retry_r   <= retry_nxt;
    end
  end

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PCT_RESET;
    end else if (cfg_we) begin
      pct_r <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

// ===== design/partial_reliability_stop_and_wait.sv =====
// ----------------------------------------------------------------------------
// partial_reliability_stop_and_wait
// Alternating-bit stop-and-wait engine with a windowed loss tolerance.
// A request beat is captured in the input register, goes through the single-pass
// update into the result register and is presented from there. Throughput: one
// request per cycle while the result channel does not stall; the input register
// and the result register each pass one beat per cycle through the update.
// Reset (rst_n low, synchronous): both registers empty, sequence bit 0,
// loss window and count cleared, tolerance back to 20 percent.
// ----------------------------------------------------------------------------
`default_nettype none

module partial_reliability_stop_and_wait (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  prsw_req_if.sink                        in_ch,
  prsw_rsp_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [prsw_pkg::PCT_W-1:0] cfg_wdata
);
  import prsw_pkg::*;

  logic   s1_v_r, s1_v_nxt;
  req_t   s1_r;
  logic   out_v_r, out_v_nxt;
  rsp_t   out_r;
  rsp_t   core_rsp;
  logic   go;
  logic   in_fire;

  // The input register moves into the result register when that one is free.
  assign go      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || go;
  assign in_fire = in_ch.valid && in_ch.ready;

  prsw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (go),
    .req       (s1_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (core_rsp)
  );

  // Valid flags of the two registers.
  always_comb begin
    s1_v_nxt  = in_fire ? 1'b1 : (go ? 1'b0 : s1_v_r);
    out_v_nxt = go ? 1'b1 : ((out_v_r && out_ch.ready) ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.req_type       <= in_ch.req_type;
      s1_r.reply_ack_flag <= in_ch.reply_ack_flag;
      s1_r.reply_ack_num  <= in_ch.reply_ack_num;
      s1_r.rx_seq         <= in_ch.rx_seq;
    end
    if (go) begin
      out_r <= core_rsp;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.action         = out_r.action;
  assign out_ch.seq_out        = out_r.seq_out;
  assign out_ch.loss_count     = out_r.loss_count;
  assign out_ch.over_threshold = out_r.over_threshold;

  // A retransmission is only ever issued over the threshold.
  a_retx_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.action == ACT_RETX |-> out_ch.over_threshold)
    else $error("retransmit issued below the loss threshold");

  // A finished message is only reported at or under the threshold.
  a_done_under: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.action == ACT_DONE |-> !out_ch.over_threshold)
    else $error("message finished while over the loss threshold");

  // A held request waits unchanged in the input register while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !go |=> s1_v_r && $stable(s1_r))
    else $error("pending request lost or changed during a stall");

  // The count never exceeds the window size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.loss_count <= LCOUNT_W'(WINDOW))
    else $error("loss count beyond window size");

endmodule

`default_nettype wire

// ===== sim/prsw_link_checker.sv =====
// ----------------------------------------------------------------------------
// prsw_link_checker
// Watches the request, result and tolerance ports of the stop-and-wait engine.
// It keeps its own copy of the link state, predicts one result beat per
// accepted request beat, and compares every result beat with the oldest
// prediction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module prsw_link_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  prsw_req_if                             req_mon,
  prsw_rsp_if                             rsp_mon,
  input  wire logic                       cfg_we,
  input  wire logic [prsw_pkg::PCT_W-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              awaited_count,
  output int                              results_seen,
  output int                              retx_seen,
  output int                              done_seen,
  output int                              peak_loss
);
  import prsw_pkg::*;

  // Shadow copy of the link state and the tolerance register.
  logic [PCT_W-1:0]  tol_pct;
  logic              link_seq;
  logic [WINDOW-1:0] loss_window;
  int unsigned       loss_total;
  int unsigned       win_idx;
  logic              resending;

  // Predicted result beats, oldest first.
  rsp_t              predicted_results[$];

  function automatic logic over_tolerance(int unsigned total, logic [PCT_W-1:0] pct);
    return (total * PCT_SCALE) > (int'(pct) * WINDOW);
  endfunction

  // Advances the shadow state by one request and returns the result it causes.
  task automatic step_link_engine(input req_t beat, output rsp_t res);
    logic    good;
    action_t act;
    logic    seq_o;
    if (win_idx >= WINDOW) win_idx = 0;
    case (req_type_t'(beat.req_type))
      REQ_START: begin
        resending = 1'b0;
        act       = ACT_TX;
        seq_o     = link_seq;
      end
      REQ_DATA: begin
        if (beat.rx_seq == link_seq) begin
          link_seq = ~link_seq;
          act      = ACT_DELIVER;
        end else begin
          act = ACT_DUP;
        end
        seq_o = beat.rx_seq;
      end
      default: begin
        // Replies and timeouts move the loss window.
        good = (beat.req_type == REQ_REPLY) && beat.reply_ack_flag &&
               (beat.reply_ack_num == link_seq);
        if (good) begin
          link_seq = ~link_seq;
          if (loss_window[win_idx]) begin
            loss_window[win_idx] = 1'b0;
            if (loss_total > 0) loss_total--;
          end
        end else if (!loss_window[win_idx] && !resending) begin
          loss_window[win_idx] = 1'b1;
          loss_total++;
        end
        if (over_tolerance(loss_total, tol_pct)) begin
          resending = 1'b1;
          act       = ACT_RETX;
        end else begin
          resending = 1'b0;
          act       = ACT_DONE;
          win_idx   = (win_idx + 1 >= WINDOW) ? 0 : win_idx + 1;
        end
        seq_o = link_seq;
      end
    endcase
    res.action         = act;
    res.seq_out        = seq_o;
    res.loss_count     = loss_total[LCOUNT_W-1:0];
    res.over_threshold = over_tolerance(loss_total, tol_pct);
    if (int'(loss_total) > peak_loss) peak_loss = int'(loss_total);
  endtask

  // Reports one field that differs.
  function automatic logic field_differs(string what, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
               $time, results_seen, what, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Sample both channels and the tolerance port at every rising edge.
  always @(posedge clk) begin
    rsp_t want;
    rsp_t next_res;
    req_t beat;
    logic bad;
    if (!rst_n) begin
      tol_pct     = PCT_RESET;
      link_seq    = 1'b0;
      loss_window = '0;
      loss_total  = 0;
      win_idx     = 0;
      resending   = 1'b0;
      predicted_results.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        results_seen++;
        if (rsp_mon.action == ACT_RETX) retx_seen++;
        if (rsp_mon.action == ACT_DONE) done_seen++;
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with none expected: action %0d seq %0d loss %0d over %0d",
                   $time, rsp_mon.action, rsp_mon.seq_out, rsp_mon.loss_count,
                   rsp_mon.over_threshold);
        end else begin
          want = predicted_results.pop_front();
          bad  = field_differs("action", 4'(want.action), 4'(rsp_mon.action)) |
                 field_differs("seq_out", 4'(want.seq_out), 4'(rsp_mon.seq_out)) |
                 field_differs("loss_count", want.loss_count, rsp_mon.loss_count) |
                 field_differs("over_threshold", 4'(want.over_threshold),
                               4'(rsp_mon.over_threshold));
          if (bad) mismatch_count++;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        beat.req_type       = req_mon.req_type;
        beat.reply_ack_flag = req_mon.reply_ack_flag;
        beat.reply_ack_num  = req_mon.reply_ack_num;
        beat.rx_seq         = req_mon.rx_seq;
        step_link_engine(beat, next_res);
        predicted_results.push_back(next_res);
      end
      if (cfg_we) tol_pct = cfg_wdata;
    end
    awaited_count <= predicted_results.size();
  end

endmodule

`default_nettype wire

// ===== sim/partial_reliability_stop_and_wait_test.sv =====
// ----------------------------------------------------------------------------
// partial_reliability_stop_and_wait_test
// Drives request beats into the stop-and-wait engine with random gaps and
// stalls the result channel at random. A short directed sequence covers the
// window corner cases, then ten tolerance settings from 0 to 127 each run a
// mix of full message exchanges, received data and random requests.
// ----------------------------------------------------------------------------
`default_nettype none

module partial_reliability_stop_and_wait_test;
  import prsw_pkg::*;

  localparam int PHASE_ITEMS = 195;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [PCT_W-1:0] cfg_wdata;

  prsw_req_if req_ch ();
  prsw_rsp_if rsp_ch ();

  int   mismatch_count;
  int   awaited_count;
  int   results_seen;
  int   retx_seen;
  int   done_seen;
  int   peak_loss;

  // Sender-side view of the shared sequence bit, kept for well-formed replies.
  logic sender_seq;
  logic sender_calm;
  int   items_sent;
  int   phase_items;
  int   tol_writes;

  partial_reliability_stop_and_wait u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  prsw_link_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_mon        (req_ch),
    .rsp_mon        (rsp_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count),
    .results_seen   (results_seen),
    .retx_seen      (retx_seen),
    .done_seen      (done_seen),
    .peak_loss      (peak_loss)
  );

  // Clock with an 8 unit period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 24);
  endfunction

  // Sends one request beat after an optional gap and waits for acceptance.
  task automatic send_req(req_type_t t, logic flag, logic num, logic rx);
    int gap;
    gap = sender_calm ? 0 : pick_idle();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= t;
    req_ch.reply_ack_flag <= flag;
    req_ch.reply_ack_num  <= num;
    req_ch.rx_seq         <= rx;
    if ((t == REQ_REPLY && flag && num == sender_seq) || (t == REQ_DATA && rx == sender_seq))
      sender_seq = ~sender_seq;
    items_sent++;
    phase_items++;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Holds the sender until every predicted result beat has arrived.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [PCT_W-1:0] pct);
    cfg_we    <= 1'b1;
    cfg_wdata <= pct;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tol_writes++;
  endtask

  // One reply to the message in flight: good, timeout, bad flag or wrong bit.
  task automatic send_reply(output logic good);
    int r;
    r    = $urandom_range(0, 99);
    good = 1'b0;
    if (r < 55) begin
      good = 1'b1;
      send_req(REQ_REPLY, 1'b1, sender_seq, 1'($urandom_range(0, 1)));
    end else if (r < 75) begin
      send_req(REQ_TIMEOUT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end else if (r < 88) begin
      send_req(REQ_REPLY, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      send_req(REQ_REPLY, 1'b1, ~sender_seq, 1'($urandom_range(0, 1)));
    end
  endtask

  // A start followed by a few replies, usually ending on a good one.
  task automatic send_message();
    int   n;
    logic good;
    send_req(REQ_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      send_reply(good);
      if (good && $urandom_range(0, 9) < 7) break;
    end
  endtask

  task automatic send_data();
    logic rx;
    rx = ($urandom_range(0, 9) < 7) ? sender_seq : ~sender_seq;
    send_req(REQ_DATA, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rx);
  endtask

  task automatic send_noise();
    send_req(req_type_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Result side: random stalls, with long stretches of steady readiness.
  initial begin
    int stall;
    int run;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_idle();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int   tol_plan[10];
    int   waited;
    tol_plan              = '{0, 100, 127, 9, 10, 50, 99, 0, 1, 20};
    tol_plan[7]           = $urandom_range(0, 127);
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = REQ_START;
    req_ch.reply_ack_flag = 1'b0;
    req_ch.reply_ack_num  = 1'b0;
    req_ch.rx_seq         = 1'b0;
    sender_seq            = 1'b0;
    sender_calm           = 1'b0;
    items_sent            = 0;
    phase_items           = 0;
    tol_writes            = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset tolerance of 20 percent.
    send_req(REQ_START, 1'b1, 1'b1, 1'b1);
    // A timeout whose ack fields look good still counts as a loss.
    send_req(REQ_TIMEOUT, 1'b1, sender_seq, 1'b1);
    send_req(REQ_REPLY, 1'b0, sender_seq, 1'b0);
    // A wrong ack bit pushes the count over the tolerance.
    send_req(REQ_REPLY, 1'b1, ~sender_seq, 1'b0);
    // A loss during retransmission must not add a mark.
    send_req(REQ_TIMEOUT, 1'b0, 1'b0, 1'b0);
    // A start abandons the message being retransmitted.
    send_req(REQ_START, 1'b0, 1'b0, 1'b0);
    send_req(REQ_REPLY, 1'b1, sender_seq, 1'b1);
    send_req(REQ_DATA, 1'b0, 1'b0, sender_seq);
    send_req(REQ_DATA, 1'b1, 1'b1, ~sender_seq);
    // A good reply with no message in flight.
    send_req(REQ_REPLY, 1'b1, sender_seq, 1'b0);
    repeat (3) send_req(REQ_TIMEOUT, 1'b1, 1'b1, 1'b0);
    // Good replies walk the window past its wrap.
    repeat (10) send_req(REQ_REPLY, 1'b1, sender_seq, 1'b1);

    // Random part, one tolerance setting per phase.
    foreach (tol_plan[p]) begin
      wait_for_results();
      write_tolerance(PCT_W'(tol_plan[p]));
      sender_calm = ($urandom_range(0, 9) < 3);
      phase_items = 0;
      // With a high tolerance a run of losses fills the whole window.
      if (tol_plan[p] >= 100)
        repeat (WINDOW + 2) send_req(REQ_TIMEOUT, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      while (phase_items < PHASE_ITEMS) begin
        case ($urandom_range(0, 99)) inside
          [0:44]:  send_message();
          [45:69]: send_data();
          [70:97]: send_noise();
          default: wait_for_results();
        endcase
      end
    end

    // Drain the result channel.
    req_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (awaited_count != 0 && waited < 5000);
    repeat (4) @(posedge clk);
    if (awaited_count != 0)
      $display("%0t: %0d expected result beats never arrived", $time, awaited_count);
    $display("Sent %0d request beats across %0d tolerance settings; %0d results checked.",
             items_sent, tol_writes + 1, results_seen);
    $display("Saw %0d retransmits, %0d finished messages, peak loss count %0d.",
             retx_seen, done_seen, peak_loss);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("** partial_reliability_stop_and_wait: PASSED **");
    end else begin
      $display("** partial_reliability_stop_and_wait: FAILED **");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #8000000;
    $display("%0t: run did not finish in time", $time);
    $display("** partial_reliability_stop_and_wait: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
